>>> hw/rtl/slt_pkg.sv
`default_nettype none

package slt_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;

    // field widths
    localparam int CMD_W   = 2;
    localparam int ID_W    = 16;
    localparam int SEG_W   = 16;
    localparam int OFS_W   = 32;
    localparam int SPEED_W = 16;

    // request command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // one stored restriction entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SEG_W-1:0]   seg;
        logic [OFS_W-1:0]   start_ofs;
        logic [OFS_W-1:0]   end_ofs;
        logic [SPEED_W-1:0] speed;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/slt_ram.sv
`default_nettype none

module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/speed_limit_table_lookup_unit.sv
`default_nettype none

// latency: a write request or unused command skips the scan and loads its result from the done state
// find and segment query: scan min(entry_count, 256) entries, no scan on an empty table
// a find that hits slot k ends its scan early at that slot
// throughput: one request at a time, next accepted in the cycle after its result loads
// reset: control state and entry_count cleared; table contents keep no reset value
module speed_limit_table_lookup_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [slt_pkg::CNT_W-1:0]     cfg_entry_count,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [slt_pkg::CMD_W-1:0]     s_command,
    input  wire logic [slt_pkg::IDX_W-1:0]     s_entry_index,
    input  wire logic [slt_pkg::ID_W-1:0]      s_entry_id,
    input  wire logic [slt_pkg::SEG_W-1:0]     s_seg_number,
    input  wire logic [slt_pkg::OFS_W-1:0]     s_start_offset,
    input  wire logic [slt_pkg::OFS_W-1:0]     s_end_offset,
    input  wire logic [slt_pkg::SPEED_W-1:0]   s_speed,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_found,
    output logic      [slt_pkg::IDX_W-1:0]     m_found_index,
    output logic      [slt_pkg::SEG_W-1:0]     m_out_seg,
    output logic      [slt_pkg::OFS_W-1:0]     m_out_start,
    output logic      [slt_pkg::OFS_W-1:0]     m_out_end,
    output logic      [slt_pkg::SPEED_W-1:0]   m_out_speed
);

    import slt_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   entry_count_reg;
    logic [CNT_W-1:0]   scan_n;

    logic [CMD_W-1:0]   cmd_reg;
    logic [ID_W-1:0]    key_id_reg;
    logic [SEG_W-1:0]   key_seg_reg;
    logic [OFS_W-1:0]   key_start_reg;
    logic [OFS_W-1:0]   key_end_reg;

    logic [CNT_W-1:0]   issue_reg;
    logic               chk_valid_reg;
    logic               chk_last_reg;
    logic [IDX_W-1:0]   chk_idx_reg;

    logic               res_found_reg;
    logic [IDX_W-1:0]   res_index_reg;
    logic [SEG_W-1:0]   res_seg_reg;
    logic [OFS_W-1:0]   res_start_reg;
    logic [OFS_W-1:0]   res_end_reg;
    logic [SPEED_W-1:0] res_speed_reg;

    logic               m_valid_reg;
    logic               m_found_reg;
    logic [IDX_W-1:0]   m_index_reg;
    logic [SEG_W-1:0]   m_seg_reg;
    logic [OFS_W-1:0]   m_start_reg;
    logic [OFS_W-1:0]   m_end_reg;
    logic [SPEED_W-1:0] m_speed_reg;

    logic               in_fire;
    logic               out_free;
    logic               load_out;
    logic               issue_en;
    logic               wr_en;
    logic               scan_cmd;
    logic               id_hit;
    logic               range_hit;
    logic               contained;
    logic               covers;
    logic               scan_end;
    entry_t             wr_entry;
    entry_t             rd_entry;

    // scan limit clamps to the table depth
    assign scan_n = (entry_count_reg > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                             : entry_count_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign scan_cmd = (s_command == CMD_FIND) || (s_command == CMD_QUERY);
    assign issue_en = (state_reg == ST_SCAN) && (issue_reg < scan_n);

    // entry compare on the word returned by the memory
    assign contained = (key_start_reg >= rd_entry.start_ofs) &&
                       (key_end_reg <= rd_entry.end_ofs);
    assign covers    = (key_start_reg < rd_entry.start_ofs) && (key_end_reg > rd_entry.end_ofs);
    assign id_hit    = chk_valid_reg && (cmd_reg == CMD_FIND) && (rd_entry.id == key_id_reg);
    assign range_hit = chk_valid_reg && (cmd_reg == CMD_QUERY) &&
                       (rd_entry.seg == key_seg_reg) && (contained || covers);
    assign scan_end  = chk_valid_reg && (chk_last_reg || id_hit);

    // write data packing
    always_comb begin
        wr_entry.id        = s_entry_id;
        wr_entry.seg       = s_seg_number;
        wr_entry.start_ofs = s_start_offset;
        wr_entry.end_ofs   = s_end_offset;
        wr_entry.speed     = s_speed;
    end

    // entry table
    slt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_entry_index),
        .wr_data (wr_entry),
        .rd_en   (issue_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (scan_cmd && (scan_n != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_SCAN: s_ready  = 1'b0;
            ST_DONE: load_out = out_free;
            default: s_ready  = 1'b0;
        endcase
    end

    assign wr_en     = in_fire && (s_command == CMD_WRITE);
    assign cfg_ready = 1'b1;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            chk_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                entry_count_reg <= cfg_entry_count;
            end
            chk_valid_reg <= issue_en && !scan_end;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scan address pipeline
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            issue_reg <= '0;
        end else if (issue_en) begin
            issue_reg <= issue_reg + CNT_W'(1);
        end
        chk_last_reg <= (issue_reg == (scan_n - CNT_W'(1)));
        chk_idx_reg  <= issue_reg[IDX_W-1:0];
    end

    // request capture and running result
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg       <= s_command;
            key_id_reg    <= s_entry_id;
            key_seg_reg   <= s_seg_number;
            key_start_reg <= s_start_offset;
            key_end_reg   <= s_end_offset;
            res_found_reg <= 1'b0;
            res_index_reg <= '0;
            res_seg_reg   <= '0;
            res_start_reg <= '0;
            res_end_reg   <= '0;
            res_speed_reg <= '0;
        end else if (id_hit) begin
            res_found_reg <= 1'b1;
            res_index_reg <= chk_idx_reg;
            res_seg_reg   <= rd_entry.seg;
            res_start_reg <= rd_entry.start_ofs;
            res_end_reg   <= rd_entry.end_ofs;
            res_speed_reg <= rd_entry.speed;
        end else if (range_hit) begin
            res_found_reg <= 1'b1;
            if (!res_found_reg || (rd_entry.speed < res_speed_reg)) begin
                res_speed_reg <= rd_entry.speed;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_found_reg <= res_found_reg;
            m_index_reg <= res_index_reg;
            m_seg_reg   <= res_seg_reg;
            m_start_reg <= res_start_reg;
            m_end_reg   <= res_end_reg;
            m_speed_reg <= res_speed_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_found_index = m_index_reg;
    assign m_out_seg     = m_seg_reg;
    assign m_out_start   = m_start_reg;
    assign m_out_end     = m_end_reg;
    assign m_out_speed   = m_speed_reg;

`ifndef SYNTHESIS
    // memory compare stage only runs while scanning
    a_chk_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |-> !chk_valid_reg)
        else $error("compare stage active outside scan");

    // read address never passes the scan limit
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_reg <= scan_n))
        else $error("scan address beyond entry count");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |->
        (m_speed_reg == '0 && m_index_reg == '0 && m_seg_reg == '0 &&
         m_start_reg == '0 && m_end_reg == '0))
        else $error("miss result with nonzero fields");

    // result appears only after the done state
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside done state");
`endif

endmodule

`default_nettype wire

>>> dv/speed_limit_table_lookup_unit_tb.sv
`timescale 1ns / 100ps

module speed_limit_table_lookup_unit_tb;
    import slt_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [SPEED_W-1:0] NO_SPEED   = 16'hFFFF;

    // one request as driven on the s_ channel
    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   slot;
        logic [ID_W-1:0]    id;
        logic [SEG_W-1:0]   seg;
        logic [OFS_W-1:0]   start_ofs;
        logic [OFS_W-1:0]   end_ofs;
        logic [SPEED_W-1:0] speed;
    } request_t;

    // one answer as seen on the m_ channel
    typedef struct {
        logic               found;
        logic [IDX_W-1:0]   slot;
        logic [SEG_W-1:0]   seg;
        logic [OFS_W-1:0]   start_ofs;
        logic [OFS_W-1:0]   end_ofs;
        logic [SPEED_W-1:0] speed;
    } answer_t;

    // restriction table mirror and queue of answers still due
    class limit_table_scoreboard;
        logic [ID_W-1:0]    id_tbl    [MAX_ENTRIES];
        logic [SEG_W-1:0]   seg_tbl   [MAX_ENTRIES];
        logic [OFS_W-1:0]   start_tbl [MAX_ENTRIES];
        logic [OFS_W-1:0]   end_tbl   [MAX_ENTRIES];
        logic [SPEED_W-1:0] speed_tbl [MAX_ENTRIES];
        int unsigned        entry_count;
        answer_t            due_answers[$];
        int                 errors;

        function new();
            entry_count = 0;
            errors = 0;
        endfunction

        function void set_entry_count(int unsigned value);
            entry_count = value;
        endfunction

        function int pending();
            return due_answers.size();
        endfunction

        // apply one request to the table and work out its answer
        function answer_t table_answer(request_t r);
            answer_t            a;
            int unsigned        n;
            bit                 hit;
            bit                 inside_rng;
            bit                 covers_rng;
            logic [SPEED_W-1:0] lowest;
            a = '{default: '0};
            n = (entry_count > MAX_ENTRIES) ? MAX_ENTRIES : entry_count;
            case (r.cmd)
                CMD_WRITE: begin
                    id_tbl[r.slot]    = r.id;
                    seg_tbl[r.slot]   = r.seg;
                    start_tbl[r.slot] = r.start_ofs;
                    end_tbl[r.slot]   = r.end_ofs;
                    speed_tbl[r.slot] = r.speed;
                end
                CMD_FIND: begin
                    // first slot whose id matches
                    for (int i = 0; i < n; i++) begin
                        if (id_tbl[i] == r.id) begin
                            a.found     = 1'b1;
                            a.slot      = i[IDX_W-1:0];
                            a.seg       = seg_tbl[i];
                            a.start_ofs = start_tbl[i];
                            a.end_ofs   = end_tbl[i];
                            a.speed     = speed_tbl[i];
                            break;
                        end
                    end
                end
                CMD_QUERY: begin
                    // minimum speed over entries that hold or sit strictly inside the range
                    hit = 1'b0;
                    lowest = NO_SPEED;
                    for (int i = 0; i < n; i++) begin
                        if (seg_tbl[i] == r.seg) begin
                            inside_rng = (r.start_ofs >= start_tbl[i]) &&
                                         (r.end_ofs <= end_tbl[i]);
                            covers_rng = (r.start_ofs < start_tbl[i]) &&
                                         (r.end_ofs > end_tbl[i]);
                            if (inside_rng || covers_rng) begin
                                if (!hit || speed_tbl[i] < lowest) begin
                                    lowest = speed_tbl[i];
                                end
                                hit = 1'b1;
                            end
                        end
                    end
                    if (hit) begin
                        a.found = 1'b1;
                        a.speed = lowest;
                    end
                end
                default: ;
            endcase
            return a;
        endfunction

        function void note_request(request_t r);
            due_answers.push_back(table_answer(r));
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want !== got) begin
                errors++;
                $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (due_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected answer, expected none, actual found=%0b speed=0x%0h",
                         $time, got.found, got.speed);
                return;
            end
            want = due_answers.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("found_index", want.slot, got.slot);
            compare_field("out_seg", want.seg, got.seg);
            compare_field("out_start", want.start_ofs, got.start_ofs);
            compare_field("out_end", want.end_ofs, got.end_ofs);
            compare_field("out_speed", want.speed, got.speed);
        endfunction
    endclass

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_entry_count = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command       = '0;
    logic [IDX_W-1:0]     s_entry_index   = '0;
    logic [ID_W-1:0]      s_entry_id      = '0;
    logic [SEG_W-1:0]     s_seg_number    = '0;
    logic [OFS_W-1:0]     s_start_offset  = '0;
    logic [OFS_W-1:0]     s_end_offset    = '0;
    logic [SPEED_W-1:0]   s_speed         = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_found;
    logic [IDX_W-1:0]     m_found_index;
    logic [SEG_W-1:0]     m_out_seg;
    logic [OFS_W-1:0]     m_out_start;
    logic [OFS_W-1:0]     m_out_end;
    logic [SPEED_W-1:0]   m_out_speed;

    limit_table_scoreboard sb;
    bit                    steady_flow = 1'b0;

    speed_limit_table_lookup_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_entry_count (cfg_entry_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_entry_index   (s_entry_index),
        .s_entry_id      (s_entry_id),
        .s_seg_number    (s_seg_number),
        .s_start_offset  (s_start_offset),
        .s_end_offset    (s_end_offset),
        .s_speed         (s_speed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_found_index   (m_found_index),
        .m_out_seg       (m_out_seg),
        .m_out_start     (m_out_start),
        .m_out_end       (m_out_end),
        .m_out_speed     (m_out_speed)
    );

    always #6 aclk = ~aclk;

    function automatic request_t make_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] slot,
                                              logic [ID_W-1:0] id, logic [SEG_W-1:0] seg,
                                              logic [OFS_W-1:0] s, logic [OFS_W-1:0] e,
                                              logic [SPEED_W-1:0] spd);
        request_t r;
        r.cmd = cmd;
        r.slot = slot;
        r.id = id;
        r.seg = seg;
        r.start_ofs = s;
        r.end_ofs = e;
        r.speed = spd;
        return r;
    endfunction

    // random request: small id and segment pools and nearby ranges so lookups hit
    function automatic request_t random_request(logic [CMD_W-1:0] cmd);
        request_t r;
        int       mode;
        r = make_request(cmd, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (cmd != CMD_UNUSED) begin
            if ($urandom_range(0, 3) != 0) r.id = $urandom_range(0, 31);
            if ($urandom_range(0, 3) != 0) r.seg = $urandom_range(0, 7);
            mode = $urandom_range(0, 3);
            if (mode == 1 || mode == 2) begin
                r.start_ofs = $urandom_range(0, 4000);
                r.end_ofs = r.start_ofs + $urandom_range(0, 4000);
            end else if (mode == 3) begin
                r.start_ofs = 32'hFFFF_E000 + $urandom_range(0, 4000);
                r.end_ofs = $urandom_range(32'hFFFF_FFFF, r.start_ofs);
            end
        end
        return r;
    endfunction

    function automatic logic [CMD_W-1:0] random_command();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 4) return CMD_WRITE;
        if (pick < 12) return CMD_FIND;
        if (pick < 19) return CMD_QUERY;
        return CMD_UNUSED;
    endfunction

    // offer one request and hold it until accepted
    task automatic send_request(request_t r);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= r.cmd;
        s_entry_index  <= r.slot;
        s_entry_id     <= r.id;
        s_seg_number   <= r.seg;
        s_start_offset <= r.start_ofs;
        s_end_offset   <= r.end_ofs;
        s_speed        <= r.speed;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_request(r);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // entry_count write, only with nothing in flight
    task automatic write_entry_count(logic [CNT_W-1:0] value);
        s_valid <= 1'b0;
        wait_idle();
        cfg_valid       <= 1'b1;
        cfg_entry_count <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        sb.set_entry_count(value);
    endtask

    // stimulus
    initial begin : stimulus
        int       phase_counts[10];
        sb = new();
        phase_counts = '{256, 511, 1, 33, 300, 255, 128, 0, 64, 200};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table: lookups scan nothing, unused code answers zero
        write_entry_count(0);
        send_request(make_request(CMD_FIND, 0, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        send_request(make_request(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));

        // four entries: extremes, a duplicate id, an inverted range
        send_request(make_request(CMD_WRITE, 0, 16'hFFFF, 16'hFFFF, 0, 32'hFFFF_FFFF, 16'hFFFF));
        send_request(make_request(CMD_WRITE, 1, 16'h1234, 5, 100, 200, 80));
        send_request(make_request(CMD_WRITE, 2, 16'h1234, 5, 150, 300, 60));
        send_request(make_request(CMD_WRITE, 3, 0, 0, 32'hFFFF_FFFF, 0, 0));
        write_entry_count(4);

        // find: first of two matches, extremes, a miss
        send_request(make_request(CMD_FIND, 0, 16'h1234, 0, 0, 0, 0));
        send_request(make_request(CMD_FIND, 0, 16'hFFFF, 0, 0, 0, 0));
        send_request(make_request(CMD_FIND, 0, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_FIND, 0, 16'h7777, 0, 0, 0, 0));

        // query: inside one, inside two, equal bounds, covering, one bound equal, extremes, inverted range
        send_request(make_request(CMD_QUERY, 0, 0, 5, 120, 180, 0));
        send_request(make_request(CMD_QUERY, 0, 0, 5, 160, 190, 0));
        send_request(make_request(CMD_QUERY, 0, 0, 5, 100, 200, 0));
        send_request(make_request(CMD_QUERY, 0, 0, 5, 50, 250, 0));
        send_request(make_request(CMD_QUERY, 0, 0, 5, 90, 200, 0));
        send_request(make_request(CMD_QUERY, 0, 0, 16'hFFFF, 0, 32'hFFFF_FFFF, 0));
        send_request(make_request(CMD_QUERY, 0, 0, 0, 5, 5, 0));

        // unused code leaves the table alone
        send_request(make_request(CMD_UNUSED, 1, 16'hFFFF, 5, 0, 0, 16'hFFFF));
        send_request(make_request(CMD_FIND, 0, 16'h1234, 0, 0, 0, 0));

        // fill every slot before larger counts are used
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            request_t w;
            w = random_request(CMD_WRITE);
            w.slot = i[IDX_W-1:0];
            send_request(w);
        end

        // random phases over a spread of table sizes
        for (int ph = 0; ph < 10; ph++) begin
            write_entry_count(phase_counts[ph][CNT_W-1:0]);
            steady_flow = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 78; k++) begin
                send_request(random_request(random_command()));
            end
        end
        s_valid <= 1'b0;

        wait_idle();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("speed_limit_table_lookup_unit_tb: PASS");
        end else begin
            $display("speed_limit_table_lookup_unit_tb: FAIL");
        end
        $finish;
    end

    // answer side: random stalls plus an occasional long hold-off
    initial begin : answer_sink
        int      gap;
        int      n_answers;
        answer_t got;
        n_answers = 0;
        do @(posedge aclk); while (!aresetn);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.found     = m_found;
                got.slot      = m_found_index;
                got.seg       = m_out_seg;
                got.start_ofs = m_out_start;
                got.end_ofs   = m_out_end;
                got.speed     = m_out_speed;
                sb.check_answer(got);
                n_answers++;
                if (n_answers % 350 == 0) begin
                    gap = 300;
                end else begin
                    gap = steady_flow ? 0 : $urandom_range(0, 3);
                end
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #20_000_000;
        $display("speed_limit_table_lookup_unit_tb: FAIL");
        $finish;
    end

endmodule
